// ===== rtl/huffman_tree_builder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_BUILDER_UNIT_MACROS_SVH
`define HUFFMAN_TREE_BUILDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define HTB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define HTB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define HTB_ASSERT(label, clk, rst, prop)
`define HTB_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/htb_pkg.sv =====
// ----------------------------------------------------------------------------
// htb_pkg
// Shared constants and codes of the Huffman tree builder.
// ----------------------------------------------------------------------------
package htb_pkg;
   localparam int SYMBOLS_DEF    = 256;
   localparam int COUNT_BITS_DEF = 16;
   localparam int MAX_NODES_DEF  = 511;

   localparam logic [1:0] MODE_DATA  = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_FETCH = 2'd2;

   localparam logic [1:0] KIND_SUMMARY = 2'd0;
   localparam logic [1:0] KIND_NODE    = 2'd1;
   localparam logic [1:0] KIND_NONE    = 2'd2;
endpackage

// ===== rtl/htb_req_if.sv =====
// ----------------------------------------------------------------------------
// htb_req_if
// Request channel: valid/ready with mode and byte payload.
// ----------------------------------------------------------------------------
interface htb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] byte_value;
   modport source (output valid, mode, byte_value, input ready);
   modport sink (input valid, mode, byte_value, output ready);
endinterface

// ===== rtl/htb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// htb_rsp_if
// Response channel: valid/ready with the result item.
// ----------------------------------------------------------------------------
interface htb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [8:0]  node_total;
   logic        bytes_dropped;
   logic        leaf_flag;
   logic [7:0]  node_label;
   logic [15:0] node_weight;
   logic        has_parent;
   logic [7:0]  parent_label;
   logic [15:0] parent_weight;
   logic        last_node;
   modport source (output valid, result_kind, node_total, bytes_dropped, leaf_flag,
      node_label, node_weight, has_parent, parent_label, parent_weight, last_node,
      input ready);
   modport sink (input valid, result_kind, node_total, bytes_dropped, leaf_flag,
      node_label, node_weight, has_parent, parent_label, parent_weight, last_node,
      output ready);
endinterface

// ===== rtl/huffman_tree_builder_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_builder_unit
// Histogram, Huffman tree construction and preorder walk over RAMs.
// ----------------------------------------------------------------------------
// After reset the unit clears its histogram RAM, one entry per cycle, and
// takes no item meanwhile. A data byte then reads its count and writes it
// back incremented. A build item reads the histogram once to count leaves
// and, if there are at least two and the tree fits, again to create them.
// Each leaf is inserted into the ordered list by reading entries and their
// weights until a heavier one is found, then shifting the tail right by one.
// A merge step reads the two lightest entries and their weights, writes the
// new node and the parent links of both children, moves the other entries
// down by two, then reinserts the new node the same way. Build cost grows
// with the square of the leaf count, set by the single read port on the
// ordered list. A fetch item pops the walk stack, reads the node and its
// parent and, for an internal node, pushes the children; a fetch with
// nothing left answers with no node. No item is taken while a result waits.
module huffman_tree_builder_unit
   import htb_pkg::*;
#(
   parameter int SYMBOLS    = SYMBOLS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int MAX_NODES  = MAX_NODES_DEF
) (
   input logic     clock,
   input logic     reset,
   htb_req_if.sink   req,
   htb_rsp_if.source rsp
);
`include "huffman_tree_builder_unit_macros.svh"

   localparam int SB = $clog2(SYMBOLS);
   localparam int NB = $clog2(MAX_NODES);
   localparam int LB = $clog2(SYMBOLS + 1);
   localparam int CB = COUNT_BITS;
   localparam int LKW = 2 + 3 * NB + 8;
   localparam logic [CB-1:0] CMAX = {CB{1'b1}};

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_DINC  = 5'd2;
   localparam logic [4:0] S_SCNT  = 5'd3;
   localparam logic [4:0] S_SCNW  = 5'd4;
   localparam logic [4:0] S_CHK   = 5'd5;
   localparam logic [4:0] S_LEAF  = 5'd6;
   localparam logic [4:0] S_LEAFW = 5'd7;
   localparam logic [4:0] S_INSR  = 5'd8;
   localparam logic [4:0] S_INSW  = 5'd9;
   localparam logic [4:0] S_INSC  = 5'd10;
   localparam logic [4:0] S_SHFR  = 5'd11;
   localparam logic [4:0] S_SHFW  = 5'd12;
   localparam logic [4:0] S_MRG0  = 5'd13;
   localparam logic [4:0] S_MRG1  = 5'd14;
   localparam logic [4:0] S_MRG2  = 5'd15;
   localparam logic [4:0] S_MRG3  = 5'd16;
   localparam logic [4:0] S_MRG4  = 5'd17;
   localparam logic [4:0] S_MRGS  = 5'd18;
   localparam logic [4:0] S_MRGT  = 5'd19;
   localparam logic [4:0] S_FIN   = 5'd20;
   localparam logic [4:0] S_FPOP  = 5'd21;
   localparam logic [4:0] S_FND   = 5'd22;
   localparam logic [4:0] S_FPAR  = 5'd23;
   localparam logic [4:0] S_FOUT  = 5'd24;
   localparam logic [4:0] S_RSP   = 5'd25;
   localparam logic [4:0] S_FLNK  = 5'd26;

   localparam logic [1:0] PH_COLLECT = 2'd0;
   localparam logic [1:0] PH_WALK    = 2'd1;
   localparam logic [1:0] PH_DONE    = 2'd2;

   typedef struct packed {
      logic          is_leaf;
      logic          has_parent;
      logic [NB-1:0] left;
      logic [NB-1:0] right;
      logic [NB-1:0] parent;
      logic [7:0]    label;
   } link_type;

   logic [4:0] st_ff, st_in;
   logic [1:0] phase_ff, phase_in;
   logic [CB-1:0] total_ff, total_in;
   logic ovf_ff, ovf_in;
   logic [SB:0] sym_ff, sym_in;
   logic [SB-1:0] byte_ff, byte_in;
   logic [LB-1:0] leaves_ff, leaves_in;
   logic [LB-1:0] olen_ff, olen_in;
   logic [LB-1:0] pos_ff, pos_in;
   logic [NB:0] made_ff, made_in;
   logic [7:0] imade_ff, imade_in;
   logic [NB-1:0] id_ff, id_in;
   logic [CB-1:0] w_ff, w_in;
   logic [NB-1:0] l_ff, l_in, r_ff, r_in;
   logic [CB-1:0] lw_ff, lw_in;
   logic [NB:0] sp_ff, sp_in;
   link_type nd_ff, nd_in;
   logic [CB-1:0] ndw_ff, ndw_in;

   logic rv_ff, rv_in;
   logic [1:0] rk_ff, rk_in;
   logic [8:0] rtot_ff, rtot_in;
   logic rdrop_ff, rdrop_in, rleaf_ff, rleaf_in, rhp_ff, rhp_in, rlast_ff, rlast_in;
   logic [7:0] rlab_ff, rlab_in, rplab_ff, rplab_in;
   logic [15:0] rw_ff, rw_in, rpw_ff, rpw_in;

   // memories
   logic cnt_we;
   logic [SB-1:0] cnt_wa, cnt_ra;
   logic [CB-1:0] cnt_wd, cnt_rd;
   logic ord_we;
   logic [SB-1:0] ord_wa, ord_ra;
   logic [NB-1:0] ord_wd, ord_rd;
   logic lnk_we;
   logic [NB-1:0] lnk_wa, lnk_ra;
   link_type lnk_wd, lnk_rd;
   logic [LKW-1:0] lnk_rdv;
   logic wt_we;
   logic [NB-1:0] wt_wa, wt_ra;
   logic [CB-1:0] wt_wd, wt_rd;
   logic stk_we;
   logic [NB-1:0] stk_wa, stk_ra;
   logic [NB-1:0] stk_wd, stk_rd;

   htb_ram #(.WIDTH(CB), .DEPTH(SYMBOLS)) u_cnt (.clock, .wr_en(cnt_we),
      .wr_addr(cnt_wa), .wr_data(cnt_wd), .rd_addr(cnt_ra), .rd_data(cnt_rd));
   htb_ram #(.WIDTH(NB), .DEPTH(SYMBOLS)) u_ord (.clock, .wr_en(ord_we),
      .wr_addr(ord_wa), .wr_data(ord_wd), .rd_addr(ord_ra), .rd_data(ord_rd));
   htb_ram #(.WIDTH(LKW), .DEPTH(MAX_NODES)) u_lnk (.clock, .wr_en(lnk_we),
      .wr_addr(lnk_wa), .wr_data(lnk_wd), .rd_addr(lnk_ra), .rd_data(lnk_rdv));
   htb_ram #(.WIDTH(CB), .DEPTH(MAX_NODES)) u_wt (.clock, .wr_en(wt_we),
      .wr_addr(wt_wa), .wr_data(wt_wd), .rd_addr(wt_ra), .rd_data(wt_rd));
   htb_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_stk (.clock, .wr_en(stk_we),
      .wr_addr(stk_wa), .wr_data(stk_wd), .rd_addr(stk_ra), .rd_data(stk_rd));
   assign lnk_rd = link_type'(lnk_rdv);

   logic take;
   logic [LB:0] two_leaves;
   assign req.ready = (st_ff == S_IDLE) && !rv_ff;
   assign take = req.valid && req.ready;
   assign two_leaves = {leaves_ff, 1'b0} - (LB+1)'(1);

   always_comb begin
      st_in = st_ff; phase_in = phase_ff; total_in = total_ff; ovf_in = ovf_ff;
      sym_in = sym_ff; byte_in = byte_ff; leaves_in = leaves_ff; olen_in = olen_ff;
      pos_in = pos_ff; made_in = made_ff; imade_in = imade_ff; id_in = id_ff;
      w_in = w_ff; l_in = l_ff; r_in = r_ff; lw_in = lw_ff; sp_in = sp_ff;
      nd_in = nd_ff; ndw_in = ndw_ff;
      rv_in = rv_ff; rk_in = rk_ff; rtot_in = rtot_ff; rdrop_in = rdrop_ff;
      rleaf_in = rleaf_ff; rlab_in = rlab_ff; rw_in = rw_ff; rhp_in = rhp_ff;
      rplab_in = rplab_ff; rpw_in = rpw_ff; rlast_in = rlast_ff;
      cnt_we = 1'b0; cnt_wa = byte_ff; cnt_wd = '0; cnt_ra = byte_ff;
      ord_we = 1'b0; ord_wa = pos_ff[SB-1:0]; ord_wd = id_ff; ord_ra = pos_ff[SB-1:0];
      lnk_we = 1'b0; lnk_wa = id_ff; lnk_wd = nd_ff; lnk_ra = id_ff;
      wt_we = 1'b0; wt_wa = id_ff; wt_wd = w_ff; wt_ra = id_ff;
      stk_we = 1'b0; stk_wa = sp_ff[NB-1:0]; stk_wd = id_ff;
      stk_ra = sp_ff[NB-1:0] - NB'(1);

      if (rv_ff && rsp.ready) begin
         rv_in = 1'b0;
      end

      unique case (st_ff)
         S_CLR: begin
            cnt_we = 1'b1; cnt_wa = sym_ff[SB-1:0];
            sym_in = sym_ff + (SB+1)'(1);
            if (sym_ff == (SB+1)'(SYMBOLS - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (take) begin
               rk_in = KIND_NONE; rtot_in = '0; rdrop_in = 1'b0; rleaf_in = 1'b0;
               rlab_in = '0; rw_in = '0; rhp_in = 1'b0; rplab_in = '0; rpw_in = '0;
               rlast_in = 1'b0;
               unique case (req.mode)
                  MODE_DATA: begin
                     if ({24'd0, req.byte_value} < 32'(SYMBOLS)) begin
                        if (total_ff == CMAX) begin
                           ovf_in = 1'b1;
                        end else begin
                           byte_in = req.byte_value[SB-1:0];
                           cnt_ra = req.byte_value[SB-1:0];
                           total_in = total_ff + CB'(1);
                           st_in = S_DINC;
                        end
                     end
                  end
                  MODE_BUILD: begin
                     sym_in = '0; leaves_in = '0; st_in = S_SCNT;
                  end
                  MODE_FETCH: begin
                     if (phase_ff != PH_WALK || sp_ff == '0) begin
                        rv_in = 1'b1;
                     end else begin
                        st_in = S_FPOP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DINC: begin
            cnt_we = 1'b1; cnt_wd = cnt_rd + CB'(1); st_in = S_IDLE;
         end
         // count distinct symbols
         S_SCNT: begin
            cnt_ra = sym_ff[SB-1:0]; st_in = S_SCNW;
         end
         S_SCNW: begin
            if (cnt_rd != '0) begin
               leaves_in = leaves_ff + LB'(1);
            end
            if (sym_ff == (SB+1)'(SYMBOLS - 1)) begin
               st_in = S_CHK;
            end else begin
               sym_in = sym_ff + (SB+1)'(1); st_in = S_SCNT;
            end
         end
         S_CHK: begin
            olen_in = '0; made_in = '0; imade_in = '0; sp_in = '0; sym_in = '0;
            if (leaves_ff < LB'(2) || 32'(two_leaves) > 32'(MAX_NODES)) begin
               phase_in = PH_DONE; rk_in = KIND_SUMMARY; rdrop_in = ovf_ff;
               rv_in = 1'b1; st_in = S_IDLE;
            end else begin
               st_in = S_LEAF;
            end
         end
         // leaf creation
         S_LEAF: begin
            if (sym_ff == (SB+1)'(SYMBOLS)) begin
               st_in = S_MRG0;
            end else begin
               cnt_ra = sym_ff[SB-1:0]; st_in = S_LEAFW;
            end
         end
         S_LEAFW: begin
            sym_in = sym_ff + (SB+1)'(1);
            if (cnt_rd == '0) begin
               st_in = S_LEAF;
            end else begin
               id_in = made_ff[NB-1:0]; w_in = cnt_rd;
               lnk_we = 1'b1; lnk_wa = made_ff[NB-1:0];
               lnk_wd = '{is_leaf: 1'b1, has_parent: 1'b0, left: '0, right: '0,
                  parent: '0, label: 8'(sym_ff[SB-1:0])};
               wt_we = 1'b1; wt_wa = made_ff[NB-1:0]; wt_wd = cnt_rd;
               made_in = made_ff + (NB+1)'(1);
               pos_in = '0; st_in = S_INSR;
            end
         end
         // insertion: find first entry heavier than w_ff
         S_INSR: begin
            if (pos_ff == olen_ff) begin
               st_in = S_SHFR; pos_in = olen_ff; lw_in = '0;
            end else begin
               ord_ra = pos_ff[SB-1:0]; st_in = S_INSW;
            end
         end
         S_INSW: begin
            wt_ra = ord_rd; st_in = S_INSC;
         end
         S_INSC: begin
            if (wt_rd <= w_ff) begin
               pos_in = pos_ff + LB'(1); st_in = S_INSR;
            end else begin
               l_in = NB'(pos_ff); pos_in = olen_ff; st_in = S_SHFR;
               lw_in = '1;
            end
         end
         // shift tail right by one, pos_ff walks down to insertion point
         S_SHFR: begin
            if (lw_ff == '0 || pos_ff == LB'(l_ff)) begin
               ord_we = 1'b1; ord_wa = pos_ff[SB-1:0]; ord_wd = id_ff;
               olen_in = olen_ff + LB'(1); lw_in = '0;
               st_in = (sym_ff == (SB+1)'(SYMBOLS)) ? S_MRG0 : S_LEAF;
               if (phase_ff == PH_COLLECT && sym_ff != (SB+1)'(SYMBOLS)) begin
                  st_in = S_LEAF;
               end
            end else begin
               ord_ra = pos_ff[SB-1:0] - SB'(1); st_in = S_SHFW;
            end
         end
         S_SHFW: begin
            ord_we = 1'b1; ord_wa = pos_ff[SB-1:0]; ord_wd = ord_rd;
            pos_in = pos_ff - LB'(1); st_in = S_SHFR;
         end
         // merge step
         S_MRG0: begin
            if (olen_ff <= LB'(1) || made_ff >= (NB+1)'(MAX_NODES)) begin
               st_in = S_FIN; ord_ra = '0;
            end else begin
               ord_ra = '0; st_in = S_MRG1;
            end
         end
         S_MRG1: begin
            l_in = ord_rd; wt_ra = ord_rd; ord_ra = SB'(1); st_in = S_MRG2;
         end
         S_MRG2: begin
            lw_in = wt_rd; r_in = ord_rd; wt_ra = ord_rd; st_in = S_MRG3;
         end
         S_MRG3: begin
            id_in = made_ff[NB-1:0]; w_in = lw_ff + wt_rd;
            wt_we = 1'b1; wt_wa = made_ff[NB-1:0]; wt_wd = lw_ff + wt_rd;
            lnk_we = 1'b1; lnk_wa = made_ff[NB-1:0];
            lnk_wd = '{is_leaf: 1'b0, has_parent: 1'b0, left: l_ff, right: r_ff,
               parent: '0, label: imade_ff};
            lnk_ra = l_ff; st_in = S_MRG4;
         end
         S_MRG4: begin
            lnk_we = 1'b1; lnk_wa = l_ff; lnk_wd = lnk_rd;
            lnk_wd.parent = id_ff; lnk_wd.has_parent = 1'b1;
            lnk_ra = r_ff; st_in = S_FLNK;
         end
         S_FLNK: begin
            lnk_we = 1'b1; lnk_wa = r_ff; lnk_wd = lnk_rd;
            lnk_wd.parent = id_ff; lnk_wd.has_parent = 1'b1;
            pos_in = LB'(2); st_in = S_MRGS;
         end
         // drop the first two entries
         S_MRGS: begin
            if (pos_ff == olen_ff) begin
               olen_in = olen_ff - LB'(2); made_in = made_ff + (NB+1)'(1);
               imade_in = imade_ff + 8'd1; pos_in = '0; st_in = S_INSR;
            end else begin
               ord_ra = pos_ff[SB-1:0]; st_in = S_MRGT;
            end
         end
         S_MRGT: begin
            ord_we = 1'b1; ord_wa = pos_ff[SB-1:0] - SB'(2); ord_wd = ord_rd;
            pos_in = pos_ff + LB'(1); st_in = S_MRGS;
         end
         S_FIN: begin
            stk_we = 1'b1; stk_wa = '0; stk_wd = ord_rd; sp_in = (NB+1)'(1);
            phase_in = PH_WALK; rk_in = KIND_SUMMARY; rtot_in = 9'(made_ff);
            rdrop_in = ovf_ff; rv_in = 1'b1; st_in = S_IDLE;
         end
         // fetch
         S_FPOP: begin
            sp_in = sp_ff - (NB+1)'(1); st_in = S_FND;
         end
         S_FND: begin
            lnk_ra = stk_rd; wt_ra = stk_rd; id_in = stk_rd; st_in = S_FPAR;
         end
         S_FPAR: begin
            nd_in = lnk_rd; ndw_in = wt_rd;
            lnk_ra = lnk_rd.parent; wt_ra = lnk_rd.parent; st_in = S_FOUT;
         end
         S_FOUT: begin
            rk_in = KIND_NODE; rleaf_in = nd_ff.is_leaf; rlab_in = nd_ff.label;
            rw_in = 16'(ndw_ff); rhp_in = nd_ff.has_parent;
            if (nd_ff.has_parent) begin
               rplab_in = lnk_rd.label; rpw_in = 16'(wt_rd);
            end
            if (!nd_ff.is_leaf) begin
               stk_we = 1'b1; stk_wa = sp_ff[NB-1:0]; stk_wd = nd_ff.right;
               st_in = S_RSP;
            end else begin
               if (sp_ff == '0) begin
                  rlast_in = 1'b1; phase_in = PH_DONE;
               end
               rv_in = 1'b1; st_in = S_IDLE;
            end
         end
         S_RSP: begin
            stk_we = 1'b1; stk_wa = sp_ff[NB-1:0] + NB'(1); stk_wd = nd_ff.left;
            sp_in = sp_ff + (NB+1)'(2); rv_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLR; phase_ff <= PH_COLLECT; total_ff <= '0; ovf_ff <= 1'b0;
         sym_ff <= '0; sp_ff <= '0; rv_ff <= 1'b0; olen_ff <= '0; made_ff <= '0;
         imade_ff <= '0; lw_ff <= '0;
      end else begin
         st_ff <= st_in; phase_ff <= phase_in; total_ff <= total_in; ovf_ff <= ovf_in;
         sym_ff <= sym_in; sp_ff <= sp_in; rv_ff <= rv_in; olen_ff <= olen_in;
         made_ff <= made_in; imade_ff <= imade_in; lw_ff <= lw_in;
      end
      byte_ff <= byte_in; leaves_ff <= leaves_in; pos_ff <= pos_in; id_ff <= id_in;
      w_ff <= w_in; l_ff <= l_in; r_ff <= r_in; nd_ff <= nd_in; ndw_ff <= ndw_in;
      rk_ff <= rk_in; rtot_ff <= rtot_in; rdrop_ff <= rdrop_in; rleaf_ff <= rleaf_in;
      rlab_ff <= rlab_in; rw_ff <= rw_in; rhp_ff <= rhp_in; rplab_ff <= rplab_in;
      rpw_ff <= rpw_in; rlast_ff <= rlast_in;
   end

   assign rsp.valid = rv_ff;
   assign rsp.result_kind = rk_ff;
   assign rsp.node_total = rtot_ff;
   assign rsp.bytes_dropped = rdrop_ff;
   assign rsp.leaf_flag = rleaf_ff;
   assign rsp.node_label = rlab_ff;
   assign rsp.node_weight = rw_ff;
   assign rsp.has_parent = rhp_ff;
   assign rsp.parent_label = rplab_ff;
   assign rsp.parent_weight = rpw_ff;
   assign rsp.last_node = rlast_ff;

   `HTB_ASSERT(a_no_take_busy, clock, reset, take |-> st_ff == S_IDLE && !rv_ff)
   `HTB_ASSERT(a_ovf_sticky, clock, reset, $past(ovf_ff) |-> ovf_ff)
   `HTB_ASSERT(a_last_done, clock, reset, (rv_ff && rlast_ff) |-> phase_ff == PH_DONE)
   `HTB_ASSERT_ALWAYS(a_reset_clr, clock, reset |=> st_ff == S_CLR && !rv_ff)
endmodule

// ===== rtl/htb_ram.sv =====
// ----------------------------------------------------------------------------
// htb_ram
// Generic single-port-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module htb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== verif/tb_huffman_tree_builder_unit.sv =====
// ----------------------------------------------------------------------------
// Huffman tree builder testbench
// Streams bytes, builds and fetch items through the unit, predicts every
// result from a local histogram and tree model and compares all fields at once.
// ----------------------------------------------------------------------------
module tb_huffman_tree_builder_unit;
   import htb_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [8:0]  total;
      logic        dropped;
      logic        leaf;
      logic [7:0]  label;
      logic [15:0] weight;
      logic        has_par;
      logic [7:0]  par_label;
      logic [15:0] par_weight;
      logic        last;
   } node_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   htb_req_if req ();
   htb_rsp_if rsp ();

   huffman_tree_builder_unit dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model state
   int unsigned hist [256];
   int unsigned byte_cnt;
   bit          ovf;
   bit          n_leaf [511];
   int unsigned n_label [511];
   int unsigned n_left [511];
   int unsigned n_right [511];
   int unsigned n_par [511];
   bit          n_haspar [511];
   int unsigned n_wt [511];
   int unsigned walk_q [$];
   bit          walking;

   node_rsp_type expected_q [$];
   int          errors = 0;
   int unsigned send_idle = 0;
   int unsigned recv_idle = 0;
   longint      cycles = 0;

   task automatic build_model(output int unsigned made);
      int unsigned ord [$];
      int unsigned leaves, l, r, pos, k;
      made = 0;
      leaves = 0;
      k = 0;
      walk_q.delete();
      for (int b = 0; b < 256; b++) if (hist[b] != 0) leaves++;
      if (leaves < 2 || 2 * leaves - 1 > 511) begin
         walking = 1'b0;
         return;
      end
      for (int b = 0; b < 256; b++) begin
         if (hist[b] != 0) begin
            n_leaf[made] = 1'b1; n_label[made] = b; n_haspar[made] = 1'b0;
            n_par[made] = 0; n_wt[made] = hist[b];
            pos = 0;
            while (pos < ord.size() && n_wt[ord[pos]] <= n_wt[made]) pos++;
            ord.insert(pos, made);
            made++;
         end
      end
      while (ord.size() > 1) begin
         l = ord.pop_front();
         r = ord.pop_front();
         n_leaf[made] = 1'b0; n_label[made] = k & 8'hff; n_left[made] = l;
         n_right[made] = r; n_haspar[made] = 1'b0;
         n_wt[made] = (n_wt[l] + n_wt[r]) & 16'hffff;
         n_par[l] = made; n_haspar[l] = 1'b1;
         n_par[r] = made; n_haspar[r] = 1'b1;
         k++;
         pos = 0;
         while (pos < ord.size() && n_wt[ord[pos]] <= n_wt[made]) pos++;
         ord.insert(pos, made);
         made++;
      end
      walk_q.insert(walk_q.size(), ord[0]);
      walking = 1'b1;
   endtask

   task automatic predict_item(input logic [1:0] mode, input logic [7:0] bv);
      node_rsp_type e;
      int unsigned made, id;
      e = '0;
      if (mode == MODE_DATA) begin
         if (byte_cnt >= 16'hffff) ovf = 1'b1;
         else begin
            hist[bv] = (hist[bv] + 1) & 16'hffff;
            byte_cnt++;
         end
         return;
      end
      if (mode == MODE_BUILD) begin
         build_model(made);
         e.kind = KIND_SUMMARY; e.total = 9'(made); e.dropped = ovf;
      end else if (mode == MODE_FETCH) begin
         if (!walking || walk_q.size() == 0) e.kind = KIND_NONE;
         else begin
            id = walk_q.pop_back();
            e.kind = KIND_NODE; e.leaf = n_leaf[id]; e.label = 8'(n_label[id]);
            e.weight = 16'(n_wt[id]);
            if (n_haspar[id]) begin
               e.has_par = 1'b1; e.par_label = 8'(n_label[n_par[id]]);
               e.par_weight = 16'(n_wt[n_par[id]]);
            end
            if (!n_leaf[id]) begin
               walk_q.insert(walk_q.size(), n_right[id]);
               walk_q.insert(walk_q.size(), n_left[id]);
            end
            if (walk_q.size() == 0) begin
               e.last = 1'b1; walking = 1'b0;
            end
         end
      end else return;
      expected_q.insert(expected_q.size(), e);
   endtask

   task automatic send_item(input logic [1:0] mode, input logic [7:0] bv);
      if (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.mode <= mode;
      req.byte_value <= bv;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_item(mode, bv);
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp.ready <= !reset && !(recv_idle != 0 && $urandom_range(99) < recv_idle);

   always @(posedge clock) begin
      node_rsp_type a, e;
      cycles <= cycles + 1;
      if (!reset && rsp.valid && rsp.ready) begin
         a = '{rsp.result_kind, rsp.node_total, rsp.bytes_dropped, rsp.leaf_flag,
               rsp.node_label, rsp.node_weight, rsp.has_parent, rsp.parent_label,
               rsp.parent_weight, rsp.last_node};
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result %h", $time, a);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (a !== e) begin
               $display("%0t mismatch expected %h actual %h", $time, e, a);
               errors++;
            end
         end
      end
   end

   always @(posedge clock)
      if (cycles > 64'd100_000_000) begin
         $display("Test completed with failures");
         $finish;
      end

   task automatic fetch_all();
      repeat (520) begin
         send_item(MODE_FETCH, 8'd0);
         if (!walking) break;
      end
      send_item(MODE_FETCH, 8'd0);
   endtask

   task automatic test_directed();
      send_item(MODE_FETCH, 8'd0);
      send_item(MODE_BUILD, 8'd0);
      send_item(MODE_DATA, 8'hff);
      send_item(MODE_UNUSED, 8'h55);
      send_item(MODE_BUILD, 8'd0);
      send_item(MODE_FETCH, 8'd0);
      send_item(MODE_DATA, 8'h00);
      send_item(MODE_DATA, 8'h00);
      send_item(MODE_DATA, 8'haa);
      send_item(MODE_DATA, 8'h55);
      send_item(MODE_BUILD, 8'd0);
      send_item(MODE_FETCH, 8'd0);
      send_item(MODE_DATA, 8'h55);
      fetch_all();
      send_item(MODE_BUILD, 8'd0);
      fetch_all();
   endtask

   task automatic test_random(input int n);
      int unsigned len;
      int unsigned alpha;
      int unsigned base;
      int sent;
      sent = 0;
      while (sent < n) begin
         len = $urandom_range(4, 30);
         alpha = $urandom_range(1, 12);
         base = $urandom_range(255);
         repeat (len) begin
            if ($urandom_range(9) == 0) send_item(2'($urandom_range(3)), 8'($urandom));
            else send_item(MODE_DATA, 8'(base + $urandom_range(alpha - 1)));
            sent++;
         end
         send_item(MODE_BUILD, 8'd0);
         repeat ($urandom_range(40)) begin
            send_item(MODE_FETCH, 8'd0);
            sent++;
         end
         sent++;
      end
   endtask

   task automatic test_full_alphabet();
      for (int b = 0; b < 256; b++) send_item(MODE_DATA, 8'(b));
      send_item(MODE_BUILD, 8'd0);
      repeat (30) send_item(MODE_FETCH, 8'd0);
   endtask

   initial begin
      req.valid = 1'b0; req.mode = MODE_DATA; req.byte_value = 8'd0;
      for (int i = 0; i < 256; i++) hist[i] = 0;
      byte_cnt = 0; ovf = 1'b0; walking = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle = 23; recv_idle = 68;
      test_directed();
      test_random(240);
      send_idle = 68; recv_idle = 23;
      test_random(240);
      send_idle = 0; recv_idle = 0;
      test_random(140);
      test_full_alphabet();
      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
